FILE: src/tvsc_pkg.sv
// ----------------------------------------------------------------------------
// tvsc_pkg: shared types and constants for the three-voice stereo chorus
// Holds the quarter-wave sine table, the fixed gains and the control codes
// passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package tvsc_pkg;

  localparam int DELAY_LEN   = 2048;
  localparam int ADDR_BITS   = $clog2(DELAY_LEN);
  localparam int VOICE_COUNT = 3;
  localparam int VOICE_BITS  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_LOG2   = $clog2(SINE_DEPTH);
  localparam int SINE_IDX_BITS = SINE_LOG2 + 1;
  localparam int SINE_SHIFT  = 14 - SINE_LOG2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Largest g with g*g*VOICE_COUNT <= 2^32
  localparam logic [15:0] INV_SQRT_GAIN = 16'd37837;

  localparam logic [16:0] GAIN_ONE = 17'd65536;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_VOICE_ONE   = 3'd0;
  localparam logic [2:0] REG_VOICE_TWO   = 3'd1;
  localparam logic [2:0] REG_VOICE_THREE = 3'd2;
  localparam logic [2:0] REG_BASE_STEP   = 3'd3;
  localparam logic [2:0] REG_MAX_MOD     = 3'd4;
  localparam logic [2:0] REG_MOD_DEPTH   = 3'd5;
  localparam logic [2:0] REG_WET_MIX     = 3'd6;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH+1];

  // Quarter-wave sine, Q1.15, by a nine-term series at elaboration
  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    longint unsigned x;
    longint unsigned t;
    longint sum;
    longint q;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x = (longint'(i) * HALF_PI_Q30) / SINE_DEPTH;
      t = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        t = (((t * x) >> 30) * x) >> 30;
        // Divide by (2k)(2k+1) for the term in hand
        case (k)
          1: t = t / 64'd6;
          2: t = t / 64'd20;
          3: t = t / 64'd42;
          4: t = t / 64'd72;
          5: t = t / 64'd110;
          6: t = t / 64'd156;
          7: t = t / 64'd210;
          default: t = t / 64'd272;
        endcase
        if (k % 2 == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      q = (sum + (64'sd1 <<< 14)) >>> 15;
      if (q > 32767) q = 32767;
      rom[i] = q[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_LOAD,
    OP_DEPTH,
    OP_SWING,
    OP_DELAY,
    OP_READ0,
    OP_READ1,
    OP_INTERP,
    OP_PAN,
    OP_ACCUM,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [VOICE_BITS-1:0] voice;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

FILE: src/tvsc_datapath.sv
// ----------------------------------------------------------------------------
// tvsc_datapath: delay ring, LFOs, interpolation and mixing
// Carries out one operation a cycle as commanded by the sequencer.
// ----------------------------------------------------------------------------
module tvsc_datapath import tvsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic signed [23:0] in_left,
  input  logic signed [23:0] in_right,
  input  logic               right_present,
  output logic signed [23:0] out_left,
  output logic signed [23:0] out_right
);

  localparam logic signed [29:0] DLY_LO = 30'sd1 <<< 16;
  localparam logic signed [29:0] DLY_HI = 30'(DELAY_LEN - 2) <<< 16;
  localparam int DLY_BITS = ADDR_BITS + 16;

  logic [63:0]          setup [VOICE_COUNT];
  logic [15:0]          phase [VOICE_COUNT];
  logic [15:0]          base_step;
  logic [11:0]          max_mod;
  logic [16:0]          depth_reg;
  logic [16:0]          mix_reg;

  logic [47:0]          mem [DELAY_LEN];
  logic [47:0]          mem_q;
  logic [ADDR_BITS-1:0] wp;
  logic [ADDR_BITS-1:0] clr_addr;
  logic [ADDR_BITS-1:0] p0;
  logic [ADDR_BITS-1:0] rd_addr;

  logic signed [23:0]   in_l, in_r;
  logic                 stereo;
  logic signed [55:0]   acc_l, acc_r;
  logic [15:0]          wet;
  logic signed [33:0]   prod_a;
  logic signed [46:0]   prod_b;
  logic [DLY_BITS-1:0]  dly;
  logic signed [23:0]   r0_l, r0_r;
  logic signed [41:0]   il, ir;
  logic signed [36:0]   pl, pr;

  logic [63:0]          su;
  logic [15:0]          ph;
  logic [14:0]          pq;
  logic [SINE_IDX_BITS-1:0] sidx;
  logic signed [15:0]   sine;
  logic [16:0]          depth_sat, mix_sat, dry;
  logic signed [29:0]   dsum;
  logic signed [24:0]   dl, dr;
  logic signed [23:0]   tl, tr;
  logic signed [27:0]   rl, rr;
  logic [27:0]          step_prod;

  // Voice setup, sine of the current phase, saturated gains, step terms and read address
  always_comb begin
    su   = setup[cmd.voice];
    ph   = phase[cmd.voice];
    pq   = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    sidx = SINE_IDX_BITS'(pq >> SINE_SHIFT);
    sine = ph[15] ? -$signed(SINE_ROM[sidx]) : $signed(SINE_ROM[sidx]);
    depth_sat = (depth_reg > GAIN_ONE) ? GAIN_ONE : depth_reg;
    mix_sat   = (mix_reg > GAIN_ONE) ? GAIN_ONE : mix_reg;
    dry       = 17'(GAIN_ONE - mix_sat);
    dsum = $signed({6'b0, su[11:0], 12'b0}) + 30'(prod_b >>> 19);
    dl = $signed(mem_q[23:0]) - 25'(r0_l);
    dr = $signed(mem_q[47:24]) - 25'(r0_r);
    tl = r0_l + 24'(il >>> 16);
    tr = r0_r + 24'(ir >>> 16);
    rl = 28'((acc_l + (56'sd1 <<< 27)) >>> 28);
    rr = 28'((acc_r + (56'sd1 <<< 27)) >>> 28);
    step_prod = base_step * su[47:36];
    case (cmd.op)
      OP_READ0: rd_addr = ADDR_BITS'(wp - dly[DLY_BITS-1:16]);
      OP_READ1: rd_addr = ADDR_BITS'(p0 - 1'b1);
      default:  rd_addr = p0;
    endcase
  end

  assign status.clear_last = (clr_addr == ADDR_BITS'(DELAY_LEN - 1));

  // Configuration registers and LFO phases
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        setup[v] <= '0;
        phase[v] <= '0;
      end
      base_step <= '0;
      max_mod   <= 12'd240;
      depth_reg <= 17'd32768;
      mix_reg   <= 17'd32768;
    end else begin
      if (cmd.op == OP_ACCUM) begin
        phase[cmd.voice] <= ph + step_prod[23:8];
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_VOICE_ONE, REG_VOICE_TWO, REG_VOICE_THREE: begin
            if (32'(cfg_index) < VOICE_COUNT) begin
              setup[VOICE_BITS'(cfg_index)] <= cfg_data;
              phase[VOICE_BITS'(cfg_index)] <= {cfg_data[59:48], 4'b0};
            end
          end
          REG_BASE_STEP: base_step <= cfg_data[15:0];
          REG_MAX_MOD:   max_mod   <= cfg_data[11:0];
          REG_MOD_DEPTH: depth_reg <= cfg_data[16:0];
          REG_WET_MIX:   mix_reg   <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
  end

  // Delay ring: at most one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (cmd.op == OP_LOAD) begin
      mem[wp] <= {in_r, in_l};
    end
    mem_q <= mem[rd_addr];
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cmd.op == OP_FINISH) wp <= wp + 1'b1;
    end
  end

  // Arithmetic pipeline, one step per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        in_l   <= in_left;
        in_r   <= right_present ? in_right : in_left;
        stereo <= right_present;
      end
      OP_LOAD: begin
        acc_l <= 56'(in_l * $signed({1'b0, dry})) <<< 12;
        acc_r <= 56'(in_r * $signed({1'b0, dry})) <<< 12;
        wet   <= 16'((33'(mix_sat) * 33'(INV_SQRT_GAIN)) >> 16);
      end
      OP_DEPTH: prod_a <= 34'(sine * $signed({1'b0, depth_sat}));
      OP_SWING: prod_b <= 47'(prod_a * $signed({1'b0, max_mod}));
      OP_DELAY: begin
        if (dsum < DLY_LO) dly <= DLY_BITS'(DLY_LO);
        else if (dsum > DLY_HI) dly <= DLY_BITS'(DLY_HI);
        else dly <= DLY_BITS'(dsum);
      end
      OP_READ0: p0 <= rd_addr;
      OP_READ1: begin
        r0_l <= $signed(mem_q[23:0]);
        r0_r <= $signed(mem_q[47:24]);
      end
      OP_INTERP: begin
        il <= 42'(dl * $signed({1'b0, dly[15:0]}));
        ir <= 42'(dr * $signed({1'b0, dly[15:0]}));
      end
      OP_PAN: begin
        pl <= 37'(tl * $signed({1'b0, su[23:12]}));
        pr <= 37'(tr * $signed({1'b0, su[35:24]}));
      end
      OP_ACCUM: begin
        acc_l <= acc_l + 56'(pl * $signed({1'b0, wet}));
        acc_r <= acc_r + 56'(pr * $signed({1'b0, wet}));
      end
      OP_FINISH: begin
        if (rl > 28'sd8388607) out_left <= 24'sd8388607;
        else if (rl < -28'sd8388608) out_left <= -24'sd8388608;
        else out_left <= 24'(rl);
        if (!stereo) out_right <= '0;
        else if (rr > 28'sd8388607) out_right <= 24'sd8388607;
        else if (rr < -28'sd8388608) out_right <= -24'sd8388608;
        else out_right <= 24'(rr);
      end
      default: ;
    endcase
  end

endmodule

FILE: src/tvsc_ctrl.sv
// ----------------------------------------------------------------------------
// tvsc_ctrl: sequencer for the chorus
// Runs the ring clearing pass, then steps each request through the voices.
// ----------------------------------------------------------------------------
module tvsc_ctrl import tvsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_LOAD   = 12'b000000000100,
    S_DEPTH  = 12'b000000001000,
    S_SWING  = 12'b000000010000,
    S_DELAY  = 12'b000000100000,
    S_READ0  = 12'b000001000000,
    S_READ1  = 12'b000010000000,
    S_INTERP = 12'b000100000000,
    S_PAN    = 12'b001000000000,
    S_ACCUM  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t                state, state_next;
  logic [VOICE_BITS-1:0] voice, voice_next;
  logic                  out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Sequence the voices
  always_comb begin
    state_next = state;
    voice_next = voice;
    cmd.op     = OP_NONE;
    cmd.voice  = voice;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_CAPTURE;
          state_next = S_LOAD;
        end
      end
      S_LOAD:   begin cmd.op = OP_LOAD;   state_next = S_DEPTH;  end
      S_DEPTH:  begin cmd.op = OP_DEPTH;  state_next = S_SWING;  end
      S_SWING:  begin cmd.op = OP_SWING;  state_next = S_DELAY;  end
      S_DELAY:  begin cmd.op = OP_DELAY;  state_next = S_READ0;  end
      S_READ0:  begin cmd.op = OP_READ0;  state_next = S_READ1;  end
      S_READ1:  begin cmd.op = OP_READ1;  state_next = S_INTERP; end
      S_INTERP: begin cmd.op = OP_INTERP; state_next = S_PAN;    end
      S_PAN:    begin cmd.op = OP_PAN;    state_next = S_ACCUM;  end
      S_ACCUM: begin
        cmd.op = OP_ACCUM;
        if (voice == VOICE_BITS'(VOICE_COUNT - 1)) begin
          voice_next = '0;
          state_next = S_DONE;
        end else begin
          voice_next = voice + 1'b1;
          state_next = S_DEPTH;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Hold state, voice and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      voice    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      voice <= voice_next;
      if (cmd.op == OP_FINISH) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready) else $error("request taken during clear");
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOAD)) else $error("accept not followed by load");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |-> out_free) else $error("result overwritten");
  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    voice <= VOICE_BITS'(VOICE_COUNT - 1)) else $error("voice out of range");

endmodule

FILE: src/three_voice_stereo_chorus_top.sv
// ----------------------------------------------------------------------------
// three_voice_stereo_chorus_top: three-voice stereo chorus
// Channel  Direction  Payload
// s_       in         tdata {in_right, in_left}, tuser right_present
// m_       out        tdata {out_right, out_left}
// cfg_     in         cfg_index register, cfg_data value (always ready)
// Each request passes through accept, load, eight steps for each of three
// voices through the shared multipliers and the single ring read port, finish.
// After reset all 2048 ring entries are cleared with s_tready low.
// A finished result waits in the output register; a stalled m_tready holds
// the next request in its finish step. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
module three_voice_stereo_chorus_top import tvsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_left[23:0], in_right[47:24]
  input  logic        s_tuser,   // right_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_left[23:0], out_right[47:24]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic signed [23:0] out_left, out_right;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_right, out_left};

  tvsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tvsc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left       (s_tdata[23:0]),
    .in_right      (s_tdata[47:24]),
    .right_present (s_tuser),
    .out_left      (out_left),
    .out_right     (out_right)
  );

endmodule
